>>> hdl/modular_exponentiation_core_assert.svh
// ----------------------------------------------------------------------------
// modular exponentiation core assertion macros
// clocked, reset-qualified property checks used by the core
// ----------------------------------------------------------------------------
`ifndef MODULAR_EXPONENTIATION_CORE_ASSERT_SVH
`define MODULAR_EXPONENTIATION_CORE_ASSERT_SVH

// property must hold at every clock edge outside reset
`define MEXP_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// condition must never be seen at a clock edge outside reset
`define MEXP_NEVER(lbl, cond, msg) \
  `MEXP_ASSERT(lbl, !(cond), msg)

`endif

>>> hdl/mexp_pkg.sv
// ----------------------------------------------------------------------------
// mexp_pkg
// shared constants and types for the modular exponentiation core
// ----------------------------------------------------------------------------
`default_nettype none

package mexp_pkg;

  // default operand width
  localparam int unsigned MOD_BITS_DEF = 32;

  // width of configuration registers, request and result fields
  localparam int unsigned REG_W = 32;

  // configuration register indexes
  localparam int unsigned CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_MODULUS  = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_EXPONENT = 1'b1;

  // status of the shared modular multiplier
  typedef struct packed {
    logic busy;
    logic done;
  } mm_stat_t;

endpackage

`default_nettype wire

>>> hdl/modular_exponentiation_core.sv
// a request with a zero exponent or modulus goes straight to the write state
//   without using the multiplier
// one request at a time: the input stalls until the result is written, and every
//   multiplication runs on the single bit-serial modular multiplier
// reset: key_modulus and key_exponent return to 1, sequencer idle, no result pending
// ----------------------------------------------------------------------------
// modular_exponentiation_core
// right-to-left square-and-multiply modular exponentiation over a shared
// bit-serial modular multiplier
// ----------------------------------------------------------------------------
`default_nettype none

`include "modular_exponentiation_core_assert.svh"

module modular_exponentiation_core #(
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  wire logic                             clk_i,
  input  wire logic                             rst_ni,
  input  wire logic                             cfg_we_i,
  input  wire logic [mexp_pkg::CFG_IDX_W-1:0]   cfg_idx_i,
  input  wire logic [mexp_pkg::REG_W-1:0]       cfg_data_i,
  input  wire logic                             in_valid_i,
  output logic                                  in_stall_o,
  input  wire logic [mexp_pkg::REG_W-1:0]       message_value_i,
  output logic                                  out_valid_o,
  input  wire logic                             out_stall_i,
  output logic      [mexp_pkg::REG_W-1:0]       power_result_o
);

  typedef enum logic [2:0] {
    S_IDLE,
    S_REDUCE,
    S_MUL,
    S_SQR,
    S_WRITE
  } state_e;

  state_e                       state_q;
  logic [mexp_pkg::REG_W-1:0]   key_modulus_q;
  logic [mexp_pkg::REG_W-1:0]   key_exponent_q;
  logic [MOD_BITS-1:0]          base_q;
  logic [MOD_BITS-1:0]          acc_q;
  logic [MOD_BITS-1:0]          expo_q;
  logic [MOD_BITS-1:0]          m_q;
  logic [mexp_pkg::REG_W-1:0]   res_q;
  logic                         out_valid_q;
  logic [mexp_pkg::REG_W-1:0]   out_data_q;
  logic                         mul_start_q;
  logic [MOD_BITS-1:0]          mul_a_q;
  logic [MOD_BITS-1:0]          mul_b_q;
  mexp_pkg::mm_stat_t           mul_stat;
  logic [MOD_BITS-1:0]          mul_res;

  logic [MOD_BITS-1:0]          msg_cut;
  logic [MOD_BITS-1:0]          mod_cut;
  logic [MOD_BITS-1:0]          exp_cut;
  logic                         in_accept;
  logic                         out_free;

  assign msg_cut   = MOD_BITS'(message_value_i);
  assign mod_cut   = MOD_BITS'(key_modulus_q);
  assign exp_cut   = MOD_BITS'(key_exponent_q);
  assign in_accept = in_valid_i && (state_q == S_IDLE);
  assign out_free  = !out_valid_q || !out_stall_i;

  mexp_modmul #(
    .MOD_BITS (MOD_BITS)
  ) u_modmul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start_q),
    .a_i      (mul_a_q),
    .b_i      (mul_b_q),
    .m_i      (m_q),
    .stat_o   (mul_stat),
    .result_o (mul_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q        <= S_IDLE;
      key_modulus_q  <= mexp_pkg::REG_W'(1);
      key_exponent_q <= mexp_pkg::REG_W'(1);
      out_valid_q    <= 1'b0;
      mul_start_q    <= 1'b0;
      base_q         <= '0;
      acc_q          <= '0;
      expo_q         <= '0;
      m_q            <= '0;
      res_q          <= '0;
      out_data_q     <= '0;
      mul_a_q        <= '0;
      mul_b_q        <= '0;
    end else begin
      mul_start_q <= 1'b0;
      // a new result in the write state takes over the output register
      if (out_valid_q && !out_stall_i && (state_q != S_WRITE)) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        unique case (cfg_idx_i)
          mexp_pkg::CFG_MODULUS:  key_modulus_q  <= cfg_data_i;
          mexp_pkg::CFG_EXPONENT: key_exponent_q <= cfg_data_i;
          default: ;
        endcase
      end
      unique case (state_q)
        S_IDLE: begin
          if (in_accept) begin
            expo_q <= exp_cut;
            m_q    <= mod_cut;
            if (exp_cut == '0) begin
              res_q   <= mexp_pkg::REG_W'(1);
              state_q <= S_WRITE;
            end else if (mod_cut == '0) begin
              res_q   <= '0;
              state_q <= S_WRITE;
            end else begin
              // 1 mod m, then reduce the base as (1 mod m) * base
              acc_q       <= (mod_cut == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
              mul_a_q     <= (mod_cut == MOD_BITS'(1)) ? '0 : MOD_BITS'(1);
              mul_b_q     <= msg_cut;
              mul_start_q <= 1'b1;
              state_q     <= S_REDUCE;
            end
          end
        end
        S_REDUCE: begin
          if (mul_stat.done) begin
            base_q      <= mul_res;
            mul_start_q <= 1'b1;
            if (expo_q[0]) begin
              mul_a_q <= acc_q;
              mul_b_q <= mul_res;
              state_q <= S_MUL;
            end else begin
              mul_a_q <= mul_res;
              mul_b_q <= mul_res;
              state_q <= S_SQR;
            end
          end
        end
        S_MUL: begin
          if (mul_stat.done) begin
            acc_q       <= mul_res;
            mul_a_q     <= base_q;
            mul_b_q     <= base_q;
            mul_start_q <= 1'b1;
            state_q     <= S_SQR;
          end
        end
        S_SQR: begin
          if (mul_stat.done) begin
            base_q <= mul_res;
            expo_q <= expo_q >> 1;
            if ((expo_q >> 1) == '0) begin
              res_q   <= mexp_pkg::REG_W'(acc_q);
              state_q <= S_WRITE;
            end else begin
              mul_start_q <= 1'b1;
              if (expo_q[1]) begin
                mul_a_q <= acc_q;
                mul_b_q <= mul_res;
                state_q <= S_MUL;
              end else begin
                mul_a_q <= mul_res;
                mul_b_q <= mul_res;
                state_q <= S_SQR;
              end
            end
          end
        end
        S_WRITE: begin
          if (out_free) begin
            out_valid_q <= 1'b1;
            out_data_q  <= res_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o     = (state_q != S_IDLE);
  assign out_valid_o    = out_valid_q;
  assign power_result_o = out_data_q;

  // the sequencer leaves idle on every accepted request
  `MEXP_ASSERT(a_busy_after_req, (in_valid_i && !in_stall_o) |=> in_stall_o,
               "request accepted but core still idle")

  // the multiplier only finishes while the sequencer waits for it
  `MEXP_NEVER(a_done_unexpected, mul_stat.done && (state_q == S_IDLE || state_q == S_WRITE),
              "multiplier finished outside a multiply state")

  // a result is only written once the multiplier has stopped
  `MEXP_ASSERT(a_write_mul_idle, (state_q == S_WRITE) |-> !mul_stat.busy,
               "result written while multiplier busy")

endmodule

`default_nettype wire

>>> hdl/mexp_modmul.sv
// ----------------------------------------------------------------------------
// mexp_modmul
// bit-serial modular multiplier: r = a * b mod m, one bit of b per cycle
// ----------------------------------------------------------------------------
`default_nettype none

module mexp_modmul #(
  parameter int unsigned MOD_BITS = mexp_pkg::MOD_BITS_DEF
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  input  wire logic                start_i,
  input  wire logic [MOD_BITS-1:0] a_i,
  input  wire logic [MOD_BITS-1:0] b_i,
  input  wire logic [MOD_BITS-1:0] m_i,
  output mexp_pkg::mm_stat_t       stat_o,
  output logic      [MOD_BITS-1:0] result_o
);

  localparam int unsigned CNT_W = $clog2(MOD_BITS);

  logic                busy_q;
  logic                done_q;
  logic [CNT_W-1:0]    cnt_q;
  logic [MOD_BITS-1:0] a_q;
  logic [MOD_BITS-1:0] b_q;
  logic [MOD_BITS-1:0] m_q;
  logic [MOD_BITS-1:0] r_q;
  logic [MOD_BITS-1:0] r_d;

  // (x + y) mod m with x and y already below m
  function automatic logic [MOD_BITS-1:0] add_mod(input logic [MOD_BITS-1:0] x,
                                                  input logic [MOD_BITS-1:0] y,
                                                  input logic [MOD_BITS-1:0] m);
    logic [MOD_BITS:0] s;
    s = {1'b0, x} + {1'b0, y};
    if (s >= {1'b0, m}) begin
      s = s - {1'b0, m};
    end
    return s[MOD_BITS-1:0];
  endfunction

  // double, then add a when the current multiplier bit is set
  always_comb begin
    r_d = add_mod(r_q, r_q, m_q);
    if (b_q[MOD_BITS-1]) begin
      r_d = add_mod(r_d, a_q, m_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= 1'b0;
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= CNT_W'(MOD_BITS - 1);
      end else if (busy_q) begin
        cnt_q <= cnt_q - 1'b1;
        if (cnt_q == '0) begin
          busy_q <= 1'b0;
          done_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      a_q <= a_i;
      b_q <= b_i;
      m_q <= m_i;
      r_q <= '0;
    end else if (busy_q) begin
      r_q <= r_d;
      b_q <= {b_q[MOD_BITS-2:0], 1'b0};
    end
  end

  assign stat_o.busy = busy_q;
  assign stat_o.done = done_q;
  assign result_o    = r_q;

endmodule

`default_nettype wire
